// ----- rtl/triggered_minmax_scope_decimator_assert.svh -----
// Assertion macros for the scope decimator RTL.
// Needs clk and rst_n in scope at the place of use.
`ifndef TRIGGERED_MINMAX_SCOPE_DECIMATOR_ASSERT_SVH
`define TRIGGERED_MINMAX_SCOPE_DECIMATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TMSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TMSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tmsd_pkg.sv -----
// Shared constants, codes and types of the scope decimator.
// No dependencies.
package tmsd_pkg;

  localparam int MAX_BLOCK   = 1024;
  localparam int MAX_COLUMNS = 64;
  localparam int AW          = $clog2(MAX_BLOCK);
  localparam int CW          = $clog2(MAX_COLUMNS) + 1;
  localparam int RW          = ((AW > CW) ? AW : CW) + 1;
  localparam int CFG_IW      = 2;
  localparam int CFG_DW      = 16;

  typedef enum logic [CFG_IW-1:0] {
    CFG_COLUMN_COUNT,
    CFG_DISPLAY_HEIGHT,
    CFG_VERTICAL_OFFSET,
    CFG_AVERAGE_WEIGHT
  } cfg_idx_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_AVG,
    DP_MID_RD,
    DP_MID_GET,
    DP_R_RD,
    DP_L_RD,
    DP_CHECK,
    DP_CLAMP,
    DP_BIN_RD,
    DP_BIN_MUL,
    DP_BIN_UPD,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_MID_RD,
    ST_MID_GET,
    ST_R_RD,
    ST_L_RD,
    ST_CHECK,
    ST_CLAMP,
    ST_ADV,
    ST_BIN_RD,
    ST_BIN_MUL,
    ST_BIN_UPD
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic srch_end;
    logic hit;
    logic adv_done;
    logic adv_emit;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/tmsd_in_if.sv -----
// Input channel of the scope decimator: valid/ready plus one sample word.
// No dependencies.
interface tmsd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_value;
  logic               block_end;

  modport source (output valid, output sample_value, output block_end, input ready);
  modport sink   (input valid, input sample_value, input block_end, output ready);
endinterface

// ----- rtl/tmsd_out_if.sv -----
// Result channel of the scope decimator: valid/ready plus one column word.
// No dependencies.
interface tmsd_out_if;
  logic              valid;
  logic              ready;
  logic        [5:0] column_index;
  logic signed [7:0] column_low;
  logic signed [7:0] column_high;
  logic              final_column;

  modport source (output valid, output column_index, output column_low,
                  output column_high, output final_column, input ready);
  modport sink   (input valid, input column_index, input column_low,
                  input column_high, input final_column, output ready);
endinterface

// ----- rtl/tmsd_ctrl.sv -----
// Sequencer of the scope decimator: steps the datapath through loading,
// trigger search, binning and column output. Depends on tmsd_pkg.
module tmsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmsd_pkg::dp_stat_t stat,
  output tmsd_pkg::dp_cmd_t  cmd
);
  import tmsd_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd.op    = DP_AVG;
        state_nxt = stat.last ? ST_MID_RD : ST_IDLE;
      end
      ST_MID_RD: begin
        cmd.op    = DP_MID_RD;
        state_nxt = ST_MID_GET;
      end
      ST_MID_GET: begin
        cmd.op    = DP_MID_GET;
        state_nxt = ST_R_RD;
      end
      ST_R_RD: begin
        cmd.op    = DP_R_RD;
        state_nxt = stat.srch_end ? ST_CLAMP : ST_L_RD;
      end
      ST_L_RD: begin
        cmd.op    = DP_L_RD;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.op    = DP_CHECK;
        state_nxt = stat.hit ? ST_CLAMP : ST_R_RD;
      end
      ST_CLAMP: begin
        cmd.op    = DP_CLAMP;
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        // Emit finished columns before the next sample is binned.
        if (stat.adv_done) begin
          state_nxt = ST_IDLE;
        end else if (stat.adv_emit) begin
          if (stat.out_free) cmd.op = DP_EMIT;
        end else begin
          state_nxt = ST_BIN_RD;
        end
      end
      ST_BIN_RD: begin
        cmd.op    = DP_BIN_RD;
        state_nxt = ST_BIN_MUL;
      end
      ST_BIN_MUL: begin
        cmd.op    = DP_BIN_MUL;
        state_nxt = ST_BIN_UPD;
      end
      ST_BIN_UPD: begin
        cmd.op    = DP_BIN_UPD;
        state_nxt = ST_ADV;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tmsd_dp.sv -----
// Datapath of the scope decimator: sample memory, average, trigger search,
// scaling, column min/max with gap fill and the output register.
// Depends on tmsd_pkg and triggered_minmax_scope_decimator_assert.svh.
module tmsd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmsd_pkg::dp_cmd_t             cmd,
  output tmsd_pkg::dp_stat_t            stat,
  input  logic signed [15:0]            in_sample,
  input  logic                          in_last,
  input  logic                          cfg_we,
  input  logic [tmsd_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [tmsd_pkg::CFG_DW-1:0]   cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [5:0]                    out_index,
  output logic signed [7:0]             out_low,
  output logic signed [7:0]             out_high,
  output logic                          out_final
);
  import tmsd_pkg::*;

  // Configuration registers.
  logic        [6:0]  col_count_r;
  logic        [6:0]  height_r;
  logic signed [15:0] offset_r;
  logic        [15:0] weight_r;

  logic [CW-1:0] w_eff;
  logic [6:0]    h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= 7'd64;
      height_r    <= 7'd64;
      offset_r    <= 16'sd0;
      weight_r    <= 16'd16;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLUMN_COUNT:    col_count_r <= cfg_data[6:0];
        CFG_DISPLAY_HEIGHT:  height_r    <= cfg_data[6:0];
        CFG_VERTICAL_OFFSET: offset_r    <= $signed(cfg_data);
        CFG_AVERAGE_WEIGHT:  weight_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (col_count_r == 7'd0) ? CW'(1) :
                 (col_count_r > 7'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(col_count_r);
  assign h_eff = (height_r < 7'd2) ? 7'd2 : height_r;

  // Sample memory, one write and one registered read port.
  logic signed [15:0] mem [MAX_BLOCK];
  logic signed [15:0] rd_r;
  logic [AW-1:0]      rd_addr;

  // Control and arithmetic state.
  logic [AW:0]        count_r;
  logic signed [31:0] avg_r;
  logic signed [49:0] aprod_r;
  logic               last_r;
  logic [AW-1:0]      n2_r;
  logic [AW-2:0]      n4_r;
  logic [AW-1:0]      i_r;
  logic signed [AW:0] shift_r;
  logic signed [15:0] a_r, b_r, c_r;
  logic [AW-1:0]      imin_r;
  logic [CW-1:0]      x_r;
  logic [RW-1:0]      rem_r;
  logic signed [24:0] ymul_r;
  logic signed [7:0]  cmax_r, cmin_r, phi_r, plo_r;
  logic               out_valid_r;
  logic [5:0]         out_index_r;
  logic signed [7:0]  out_low_r, out_high_r;
  logic               out_final_r;

  logic signed [32:0] diff;
  logic signed [16:0] wt_s;
  logic               a_lt, b_gt, c_gt, d_lt, hit_r, hit_l;
  logic signed [AW:0] i_s, n4_s, sh_c;
  logic signed [AW+1:0] imin_full;
  logic signed [16:0] sum_s;
  logic signed [7:0]  hm1_s;
  logic signed [24:0] ybias;
  logic signed [9:0]  yq, h_s;
  logic signed [7:0]  y8, neg_h, pos_h, hi_f, lo_f;
  logic               out_free;

  assign diff  = {in_sample[15], in_sample, 16'h0000} - {avg_r[31], avg_r};
  assign wt_s  = $signed({1'b0, weight_r});

  always_comb begin
    unique case (cmd.op)
      DP_R_RD:   rd_addr = n2_r + i_r;
      DP_L_RD:   rd_addr = n2_r - i_r;
      DP_BIN_RD: rd_addr = imin_r + i_r;
      default:   rd_addr = n2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == DP_LOAD) && (count_r < (AW+1)'(MAX_BLOCK))) begin
      mem[count_r[AW-1:0]] <= in_sample;
    end
    rd_r <= mem[rd_addr];
  end

  // Crossing tests against the level, with the sample taken as Q1.31.
  assign a_lt  = $signed({a_r, 16'h0000}) < avg_r;
  assign b_gt  = $signed({b_r, 16'h0000}) > avg_r;
  assign c_gt  = $signed({c_r, 16'h0000}) > avg_r;
  assign d_lt  = $signed({rd_r, 16'h0000}) < avg_r;
  assign hit_r = a_lt && b_gt;
  assign hit_l = c_gt && d_lt;

  assign i_s  = $signed({1'b0, i_r});
  assign n4_s = $signed({2'b00, n4_r});
  assign sh_c = (shift_r > n4_s) ? n4_s : ((shift_r < -n4_s) ? -n4_s : shift_r);
  assign imin_full = $signed({2'b00, n2_r}) + {sh_c[AW], sh_c} - $signed({3'b000, n4_r});

  // Pixel scaling: truncation toward zero, then saturation to the height.
  assign sum_s = {offset_r[15], offset_r} + {rd_r[15], rd_r};
  assign hm1_s = $signed({1'b0, h_eff - 7'd1});
  assign ybias = ymul_r + (ymul_r[24] ? 25'sd65535 : 25'sd0);
  assign yq    = {ybias[24], ybias[24:16]};
  assign h_s   = $signed({3'b000, h_eff});
  assign pos_h = $signed({1'b0, h_eff});
  assign neg_h = -pos_h;
  assign y8    = (yq > h_s) ? pos_h : ((yq < -h_s) ? neg_h : yq[7:0]);

  // Gap fill against the previous column as already emitted.
  assign hi_f = ((x_r != '0) && (cmax_r < plo_r)) ? plo_r : cmax_r;
  assign lo_f = ((x_r != '0) && (cmin_r > phi_r)) ? phi_r : cmin_r;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      avg_r       <= 32'sd0;
      shift_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == DP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        DP_LOAD: begin
          aprod_r <= diff * wt_s;
          last_r  <= in_last;
          if (count_r < (AW+1)'(MAX_BLOCK)) count_r <= count_r + 1'b1;
        end
        DP_AVG: begin
          avg_r <= avg_r + aprod_r[47:16];
          if (last_r) begin
            n2_r    <= count_r[AW:1];
            n4_r    <= count_r[AW:2];
            count_r <= '0;
          end
        end
        DP_MID_GET: begin
          a_r <= rd_r;
          c_r <= rd_r;
          i_r <= AW'(1);
        end
        DP_L_RD: begin
          b_r <= rd_r;
        end
        DP_CHECK: begin
          if (hit_r) begin
            shift_r <= i_s;
          end else if (hit_l) begin
            shift_r <= -i_s;
          end else begin
            a_r <= b_r;
            c_r <= rd_r;
            i_r <= i_r + 1'b1;
          end
        end
        DP_CLAMP: begin
          shift_r <= sh_c;
          imin_r  <= imin_full[AW-1:0];
          i_r     <= '0;
          x_r     <= '0;
          rem_r   <= '0;
          cmax_r  <= neg_h;
          cmin_r  <= pos_h;
        end
        DP_BIN_MUL: begin
          ymul_r <= sum_s * hm1_s;
        end
        DP_BIN_UPD: begin
          if (y8 > cmax_r) cmax_r <= y8;
          if (y8 < cmin_r) cmin_r <= y8;
          i_r   <= i_r + 1'b1;
          rem_r <= rem_r + RW'(w_eff);
        end
        DP_EMIT: begin
          out_index_r <= x_r[5:0];
          out_low_r   <= lo_f;
          out_high_r  <= hi_f;
          out_final_r <= (x_r == (w_eff - 1'b1));
          phi_r       <= hi_f;
          plo_r       <= lo_f;
          x_r         <= x_r + 1'b1;
          rem_r       <= rem_r - RW'(n2_r);
          cmax_r      <= neg_h;
          cmin_r      <= pos_h;
        end
        default: ;
      endcase
    end
  end

  assign stat.last     = last_r;
  assign stat.srch_end = (i_r >= {1'b0, n4_r});
  assign stat.hit      = hit_r || hit_l;
  assign stat.adv_done = (x_r == w_eff);
  assign stat.adv_emit = (rem_r >= RW'(n2_r));
  assign stat.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_low   = out_low_r;
  assign out_high  = out_high_r;
  assign out_final = out_final_r;

`include "triggered_minmax_scope_decimator_assert.svh"

  `TMSD_ASSERT_IMP(a_emit_free, cmd.op == DP_EMIT, out_free, "column emitted over a waiting word")
  `TMSD_ASSERT_IMP(a_emit_range, cmd.op == DP_EMIT, x_r < w_eff, "column index beyond width")
  `TMSD_ASSERT_IMP(a_bin_range, cmd.op == DP_BIN_RD, i_r < n2_r, "binning beyond half block")
  `TMSD_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(cmd.op == DP_EMIT), "stray output word")
  `TMSD_ASSERT_NXT(a_shift_clamp, cmd.op == DP_CLAMP, (shift_r <= n4_s) && (shift_r >= -n4_s), "shift left unclamped")

endmodule

// ----- rtl/triggered_minmax_scope_decimator.sv -----
// Triggered min/max scope decimator.
// Channels: in_ch takes one Q1.15 sample word per handshake, block_end on the
// last word of a block; out_ch gives one word per display column, min and
// max pixel offsets after gap fill, final_column on the last one.
// The cfg port writes column count, height, vertical offset and average
// weight on an edge with cfg_we high; the user must write it only while
// the block is idle, which the block itself does not enforce.
// Each sample word passes through the average multiply, then its add,
// before input is ready again. A block-end word then blocks input while
// the trigger search runs, a step of right read, left read and check out
// to a quarter of the block, and binning runs over half the block, an
// advance, read, multiply and update per sample from the single read port
// of the sample memory, with each finished column emitted in the advance.
// Reset clears the sample count, level, shift and state; the sample memory
// needs no clearing. If out_ch stalls, column output and binning wait on the
// held output register and no word is lost.
// Depends on tmsd_pkg, tmsd_in_if, tmsd_out_if, tmsd_ctrl and tmsd_dp.
module triggered_minmax_scope_decimator (
  input  logic                        clk,
  input  logic                        rst_n,
  tmsd_in_if.sink                     in_ch,
  tmsd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [tmsd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tmsd_pkg::CFG_DW-1:0] cfg_data
);
  import tmsd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tmsd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_sample (in_ch.sample_value),
    .in_last   (in_ch.block_end),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_index (out_ch.column_index),
    .out_low   (out_ch.column_low),
    .out_high  (out_ch.column_high),
    .out_final (out_ch.final_column)
  );

endmodule
